// ----- rtl/msbm_pkg.sv -----
// Shared constants, codes and transaction types of the multi-signature byte matcher.
// Every other file in rtl/ refers to this package by scoped names.
package msbm_pkg;

    localparam int NUM_SIGS      = 16;
    localparam int MAX_SIG_LEN   = 32;
    localparam int POSITION_BITS = 24;

    // Only slots that the 4-bit slot field can address are ever scanned.
    localparam int SLOT_LIMIT = (NUM_SIGS < 16) ? NUM_SIGS : 16;

    localparam int SLOT_AW = (NUM_SIGS > 1) ? $clog2(NUM_SIGS) : 1;
    localparam int MATCH_W = (SLOT_LIMIT > 1) ? $clog2(SLOT_LIMIT) : 1;
    localparam int IDX_W   = (MAX_SIG_LEN > 1) ? $clog2(MAX_SIG_LEN) : 1;
    localparam int LEN_W   = $clog2(MAX_SIG_LEN + 1);
    localparam int ROW_W   = MAX_SIG_LEN * 8;
    localparam int POS_W1  = POSITION_BITS + 1;
    localparam int OFFSET_W = 24;

    localparam logic [1:0] KIND_LOAD_BYTE = 2'd0;
    localparam logic [1:0] KIND_SET_LEN   = 2'd1;
    localparam logic [1:0] KIND_SCAN      = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] slot;
        logic [4:0] byte_index;
        logic [7:0] value;
        logic       end_of_buffer;
    } t_in_item;

    typedef struct packed {
        logic [23:0] start_offset;
        logic [3:0]  match_slot;
        logic [5:0]  match_length;
        logic        last_match;
        logic        offset_saturated;
    } t_out_item;

    // Byte write into the signature memory.
    typedef struct packed {
        logic               en;
        logic [SLOT_AW-1:0] slot;
        logic [IDX_W-1:0]   idx;
        logic [7:0]         value;
    } t_sig_wr;

endpackage

// ----- rtl/msbm_sig_mem.sv -----
// Signature byte memory: one row of all signature bytes per slot, byte writes,
// one registered read port. Depends on msbm_pkg.
module msbm_sig_mem (
    input  logic                               i_clk,
    input  msbm_pkg::t_sig_wr                  i_wr,
    input  logic                               i_rd_en,
    input  logic [msbm_pkg::SLOT_AW-1:0]       i_rd_addr,
    output logic [msbm_pkg::ROW_W-1:0]         o_rd_data
);

    logic [msbm_pkg::ROW_W-1:0] r_mem [msbm_pkg::NUM_SIGS];
    logic [msbm_pkg::ROW_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.slot][i_wr.idx*8 +: 8] <= i_wr.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/msbm_window.sv -----
// History window of the most recent scanned bytes and the comparator that lines
// a signature row up against it. Depends on msbm_pkg.
module msbm_window (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_shift,
    input  logic [7:0]                        i_byte,
    input  logic [msbm_pkg::LEN_W-1:0]        i_len,
    input  logic [msbm_pkg::ROW_W-1:0]        i_row,
    output logic                              o_equal
);

    localparam int ML = msbm_pkg::MAX_SIG_LEN;
    localparam int LW = msbm_pkg::LEN_W;
    localparam int RW = msbm_pkg::ROW_W;

    logic [7:0]    r_hist [ML];   // entry 0 holds the newest byte
    logic [RW-1:0] flat_oldest;
    logic [RW-1:0] aligned;
    logic [LW-1:0] shift_bytes;
    logic [ML-1:0] byte_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ML; i++) begin
                r_hist[i] <= 8'd0;
            end
        end else if (i_shift) begin
            r_hist[0] <= i_byte;
            for (int i = 1; i < ML; i++) begin
                r_hist[i] <= r_hist[i-1];
            end
        end
    end

    // Oldest byte first, then shifted so that signature byte k faces the byte
    // that arrived len-1-k scan transactions ago.
    always_comb begin
        for (int j = 0; j < ML; j++) begin
            flat_oldest[j*8 +: 8] = r_hist[ML-1-j];
        end
        shift_bytes = LW'(ML) - i_len;
        aligned     = flat_oldest >> {shift_bytes, 3'b000};
        for (int k = 0; k < ML; k++) begin
            byte_ok[k] = (LW'(k) >= i_len) || (aligned[k*8 +: 8] == i_row[k*8 +: 8]);
        end
    end

    assign o_equal = &byte_ok;

endmodule

// ----- rtl/multi_signature_byte_matcher.sv -----
// Multi-signature byte matcher, top level: transaction handshakes, length table,
// scan sequencer and result register. Depends on msbm_pkg, msbm_sig_mem, msbm_window.
//
// Usage. The input channel carries load-byte, set-length and scan transactions;
// the output channel carries one transaction per signature that ends on a scanned
// byte, in increasing slot order, the last one flagged with last_match.
// Load and length transactions produce nothing and do not occupy the block. A scan
// transaction shifts its byte into the history window, then the sequencer reads
// one signature row per cycle from the signature memory and compares it in full
// against the window, for the 16 slots. Matches are then delivered one per cycle
// from the output register while the receiver does not stall. o_in_stall stays
// high through the scan and until the last match has moved into the output
// register (or the scan has found none), and longer while the receiver stalls.
// The output register holds a finished result while the block returns to idle,
// so the next transaction can be accepted before the last result is taken.
// Reset clears the lengths (all slots empty), the history window, the byte
// position and the output valid; signature bytes are undefined until loaded.
// While i_out_stall is high the pending result holds and delivery of further
// matches pauses.
module multi_signature_byte_matcher (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  msbm_pkg::t_in_item    i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output msbm_pkg::t_out_item   o_out_data
);

    localparam int NS  = msbm_pkg::NUM_SIGS;
    localparam int ML  = msbm_pkg::MAX_SIG_LEN;
    localparam int LW  = msbm_pkg::LEN_W;
    localparam int SAW = msbm_pkg::SLOT_AW;
    localparam int MW  = msbm_pkg::MATCH_W;
    localparam int SL  = msbm_pkg::SLOT_LIMIT;
    localparam int PW  = msbm_pkg::POSITION_BITS;
    localparam int PW1 = msbm_pkg::POS_W1;
    localparam int OW  = msbm_pkg::OFFSET_W;
    localparam logic [MW-1:0] LAST_SLOT = MW'(SL - 1);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_EMIT} t_state;

    t_state               r_state;
    logic [LW-1:0]        r_len [NS];
    logic [PW-1:0]        r_pos;
    logic                 r_sat;
    logic [PW-1:0]        r_pos_snap;
    logic                 r_sat_snap;
    logic [MW-1:0]        r_cnt;
    logic                 r_issuing;
    logic                 r_cmp_valid;
    logic [MW-1:0]        r_cmp_slot;
    logic [LW-1:0]        r_len_q;
    logic [SL-1:0]        r_match;
    logic                 r_out_valid;
    msbm_pkg::t_out_item  r_out_data;

    logic                 accept;
    logic                 slot_ok;
    logic                 idx_ok;
    logic [LW-1:0]        len_in;
    msbm_pkg::t_sig_wr    sig_wr;
    logic [ML*8-1:0]      row_data;
    logic                 row_equal;
    logic                 len_ok;
    logic                 hit;
    logic [SL-1:0]        pick_onehot;
    logic [MW-1:0]        pick_idx;
    logic [MW-1:0]        rd_slot;
    logic [LW-1:0]        len_rd;
    logic                 pick_last;
    logic [PW1-1:0]       n_offset;
    logic                 emit_fire;

    assign accept  = i_in_valid && (r_state == ST_IDLE);
    assign slot_ok = 8'(i_in_data.slot) < 8'(NS);
    assign idx_ok  = 8'(i_in_data.byte_index) < 8'(ML);
    assign len_in  = ({1'b0, i_in_data.value} > 9'(ML)) ? LW'(ML) : LW'(i_in_data.value);

    always_comb begin
        sig_wr.en    = accept && (i_in_data.kind == msbm_pkg::KIND_LOAD_BYTE)
                       && slot_ok && idx_ok;
        sig_wr.slot  = SAW'(i_in_data.slot);
        sig_wr.idx   = msbm_pkg::IDX_W'(i_in_data.byte_index);
        sig_wr.value = i_in_data.value;
    end

    msbm_sig_mem u_sig_mem (
        .i_clk     (i_clk),
        .i_wr      (sig_wr),
        .i_rd_en   ((r_state == ST_SCAN) && r_issuing),
        .i_rd_addr (SAW'(r_cnt)),
        .o_rd_data (row_data)
    );

    msbm_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (accept && (i_in_data.kind == msbm_pkg::KIND_SCAN)),
        .i_byte  (i_in_data.value),
        .i_len   (r_len_q),
        .i_row   (row_data),
        .o_equal (row_equal)
    );

    // A signature must lie wholly inside the current buffer unless the
    // position has saturated.
    assign len_ok = (r_len_q != '0)
                    && (r_sat_snap || ((PW1'(r_pos_snap) + PW1'(1)) >= PW1'(r_len_q)));
    assign hit    = r_cmp_valid && len_ok && row_equal;

    // A match moves into the output register when the register is free or
    // its transaction is being taken.
    assign emit_fire = (r_state == ST_EMIT) && (r_match != '0)
                       && (!r_out_valid || !i_out_stall);

    always_comb begin
        pick_onehot = r_match & (~r_match + SL'(1));
        pick_idx    = '0;
        for (int j = 0; j < SL; j++) begin
            if (pick_onehot[j]) begin
                pick_idx = pick_idx | MW'(j);
            end
        end
        pick_last = (r_match & ~pick_onehot) == '0;
        rd_slot   = (r_state == ST_EMIT) ? pick_idx : r_cnt;
        len_rd    = r_len[SAW'(rd_slot)];
        n_offset  = PW1'(r_pos_snap) + PW1'(1) - PW1'(len_rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            for (int i = 0; i < NS; i++) begin
                r_len[i] <= '0;
            end
            r_pos       <= '0;
            r_sat       <= 1'b0;
            r_issuing   <= 1'b0;
            r_cmp_valid <= 1'b0;
            r_match     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit_fire) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            r_cmp_valid <= (r_state == ST_SCAN) && r_issuing;
            r_cmp_slot  <= r_cnt;
            r_len_q     <= len_rd;

            case (r_state)
                ST_IDLE: begin
                    if (accept && (i_in_data.kind == msbm_pkg::KIND_SET_LEN) && slot_ok) begin
                        r_len[SAW'(i_in_data.slot)] <= len_in;
                    end
                    if (accept && (i_in_data.kind == msbm_pkg::KIND_SCAN)) begin
                        r_pos_snap <= r_pos;
                        r_sat_snap <= r_sat;
                        if (i_in_data.end_of_buffer) begin
                            r_pos <= '0;
                            r_sat <= 1'b0;
                        end else if (r_pos == '1) begin
                            r_sat <= 1'b1;
                        end else begin
                            r_pos <= r_pos + PW'(1);
                        end
                        r_cnt     <= '0;
                        r_issuing <= 1'b1;
                        r_match   <= '0;
                        r_state   <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (r_issuing) begin
                        if (r_cnt == LAST_SLOT) begin
                            r_issuing <= 1'b0;
                        end else begin
                            r_cnt <= r_cnt + MW'(1);
                        end
                    end
                    if (hit) begin
                        r_match[r_cmp_slot] <= 1'b1;
                    end
                    if (r_cmp_valid && (r_cmp_slot == LAST_SLOT)) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (r_match == '0) begin
                        r_state <= ST_IDLE;
                    end else if (emit_fire) begin
                        r_out_data.start_offset     <= OW'(n_offset);
                        r_out_data.match_slot       <= 4'(pick_idx);
                        r_out_data.match_length     <= 6'(len_rd);
                        r_out_data.last_match       <= pick_last;
                        r_out_data.offset_saturated <= r_sat_snap;
                        r_match                     <= r_match & ~pick_onehot;
                        if (pick_last) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- rtl/msbm_checker.sv -----
// Port-level checker for the multi-signature byte matcher, bound to the top level.
// Depends on msbm_pkg and multi_signature_byte_matcher.
module msbm_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input msbm_pkg::t_in_item    i_in_data,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input msbm_pkg::t_out_item   o_out_data
);

    // A stalled result transaction stays offered unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result transaction changed or was dropped");

    // Reset leaves the block idle with nothing to deliver.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not idle after reset");

    // Load and length transactions never occupy the block.
    a_load_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_data.kind != msbm_pkg::KIND_SCAN)
        |=> !o_in_stall)
        else $error("block busy after a load transaction");

    // Reported lengths lie in the signature range.
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.match_length != 6'd0)
                        && (7'(o_out_data.match_length) <= 7'(msbm_pkg::MAX_SIG_LEN)))
        else $error("result length out of range");

endmodule

bind multi_signature_byte_matcher msbm_checker u_msbm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for multi_signature_byte_matcher: a directed table, then random
// signature programming and scan traffic, checked against a predictor. Needs msbm_pkg.
module tb;

    localparam logic [1:0]  KIND_UNUSED = 2'd3;
    localparam logic [23:0] POS_LIMIT   = 24'hFFFFFF;
    localparam int ITEM_TARGET  = 450;
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int DRAIN_CYCLES = 64;

    typedef enum logic [1:0] {CHK_PREDICT, CHK_NONE, CHK_ONE} t_row_check;

    logic                 i_clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    msbm_pkg::t_in_item   in_data   = '0;
    logic                 out_stall = 1'b0;
    logic                 in_stall;
    logic                 out_valid;
    msbm_pkg::t_out_item  out_data;

    multi_signature_byte_matcher dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    // Predictor state.
    logic [7:0]  sig_mem [msbm_pkg::NUM_SIGS][msbm_pkg::MAX_SIG_LEN];
    logic [5:0]  sig_len [msbm_pkg::NUM_SIGS];
    logic [7:0]  hist [msbm_pkg::MAX_SIG_LEN];
    logic [23:0] scan_pos;
    logic        pos_sat;
    logic [msbm_pkg::MAX_SIG_LEN-1:0] loaded_mask [msbm_pkg::NUM_SIGS];

    msbm_pkg::t_out_item  new_matches [$];
    msbm_pkg::t_out_item  pending_matches [$];
    msbm_pkg::t_in_item   dir_items [$];
    t_row_check           dir_checks [$];
    msbm_pkg::t_out_item  dir_wants [$];

    int mismatches = 0;
    int cycle_count = 0;
    int items_sent = 0;
    int scans_sent = 0;
    int matches_predicted = 0;
    int matches_checked = 0;
    msbm_pkg::t_out_item got_match;
    msbm_pkg::t_out_item want_match;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("cycle %0d: %s", cycle_count, what);
    endtask

    // Advances the predictor by one input transaction and leaves its matches in new_matches.
    task automatic apply_item(input msbm_pkg::t_in_item it);
        int s;
        int k;
        logic [15:0] hit_vec;
        int top_slot;
        logic [5:0] len;
        new_matches.delete();
        case (it.kind)
            msbm_pkg::KIND_LOAD_BYTE: begin
                sig_mem[it.slot][it.byte_index] = it.value;
                loaded_mask[it.slot][it.byte_index] = 1'b1;
            end
            msbm_pkg::KIND_SET_LEN: begin
                sig_len[it.slot] = (it.value > msbm_pkg::MAX_SIG_LEN) ?
                                   6'(msbm_pkg::MAX_SIG_LEN) : it.value[5:0];
            end
            msbm_pkg::KIND_SCAN: begin
                for (k = msbm_pkg::MAX_SIG_LEN - 1; k > 0; k--)
                    hist[k] = hist[k-1];
                hist[0] = it.value;
                hit_vec = '0;
                top_slot = -1;
                for (s = 0; s < msbm_pkg::SLOT_LIMIT; s++) begin
                    len = sig_len[s];
                    if (len == 0)
                        continue;
                    // A match may not reach back into the previous buffer.
                    if (!pos_sat && {19'd0, len} > {1'b0, scan_pos} + 25'd1)
                        continue;
                    hit_vec[s] = 1'b1;
                    for (k = 0; k < len; k++)
                        if (hist[len - 1 - k] != sig_mem[s][k])
                            hit_vec[s] = 1'b0;
                    if (hit_vec[s])
                        top_slot = s;
                end
                for (s = 0; s < msbm_pkg::SLOT_LIMIT; s++) begin
                    if (hit_vec[s])
                        new_matches.push_back({scan_pos + 24'd1 - 24'(sig_len[s]), 4'(s),
                                               sig_len[s], s == top_slot, pos_sat});
                end
                if (it.end_of_buffer) begin
                    scan_pos = '0;
                    pos_sat = 1'b0;
                end else if (scan_pos == POS_LIMIT) begin
                    pos_sat = 1'b1;
                end else begin
                    scan_pos = scan_pos + 24'd1;
                end
            end
            default: ;
        endcase
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if ((items_sent % 80) < 20 || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // A small alphabet keeps short signatures matching often.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h5A;
            3: return 8'hA5;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int loaded_prefix(input int s);
        int n;
        n = 0;
        while (n < msbm_pkg::MAX_SIG_LEN && loaded_mask[s][n])
            n++;
        return n;
    endfunction

    // Drives one transaction after a random gap, waits for it to be taken and
    // queues what it should produce.
    task automatic send_item(input msbm_pkg::t_in_item it, input t_row_check chk,
                             input msbm_pkg::t_out_item want);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge i_clk);
        while (in_stall)
            @(posedge i_clk);
        apply_item(it);
        if (it.kind != KIND_UNUSED)
            items_sent++;
        if (it.kind == msbm_pkg::KIND_SCAN)
            scans_sent++;
        case (chk)
            CHK_ONE: pending_matches.push_back(want);
            CHK_NONE: ;
            default: begin
                foreach (new_matches[i])
                    pending_matches.push_back(new_matches[i]);
            end
        endcase
        if (chk == CHK_ONE)
            matches_predicted++;
        else if (chk == CHK_PREDICT)
            matches_predicted += new_matches.size();
    endtask

    task automatic add_row(input msbm_pkg::t_in_item it, input t_row_check chk,
                           input msbm_pkg::t_out_item want);
        dir_items.push_back(it);
        dir_checks.push_back(chk);
        dir_wants.push_back(want);
    endtask

    task automatic program_signature();
        int s;
        int n;
        int k;
        int r;
        logic [7:0] len_val;
        s = $urandom_range(0, msbm_pkg::NUM_SIGS - 1);
        r = $urandom_range(0, 9);
        n = (r < 7) ? $urandom_range(1, 4) : (r < 9) ? $urandom_range(5, 31) :
            msbm_pkg::MAX_SIG_LEN;
        for (k = 0; k < n; k++)
            send_item({msbm_pkg::KIND_LOAD_BYTE, 4'(s), 5'(k), pick_byte(), 1'($urandom)},
                      CHK_PREDICT, '0);
        len_val = 8'(n);
        // Lengths above the maximum saturate.
        if (n == msbm_pkg::MAX_SIG_LEN && $urandom_range(0, 1) == 1)
            len_val = 8'($urandom_range(33, 255));
        send_item({msbm_pkg::KIND_SET_LEN, 4'(s), 5'($urandom), len_val, 1'($urandom)},
                  CHK_PREDICT, '0);
    endtask

    task automatic scan_burst();
        int n;
        int k;
        logic eob;
        n = $urandom_range(1, 12);
        for (k = 0; k < n; k++) begin
            eob = ((k == n - 1) && $urandom_range(0, 99) < 30) || $urandom_range(0, 99) < 3;
            send_item({msbm_pkg::KIND_SCAN, 4'($urandom), 5'($urandom), pick_byte(), eob},
                      CHK_PREDICT, '0);
        end
    endtask

    // Scans the bytes of a programmed signature so that it is found; with no signature programmed, sends a scan burst.
    task automatic scan_planted();
        int s;
        int k;
        int start;
        s = -1;
        start = $urandom_range(0, msbm_pkg::NUM_SIGS - 1);
        for (k = 0; k < msbm_pkg::NUM_SIGS; k++)
            if (s < 0 && sig_len[(start + k) % msbm_pkg::NUM_SIGS] != 0)
                s = (start + k) % msbm_pkg::NUM_SIGS;
        if (s < 0) begin
            scan_burst();
        end else begin
            if ($urandom_range(0, 2) == 0)
                send_item({msbm_pkg::KIND_SCAN, 4'($urandom), 5'($urandom), pick_byte(), 1'b0},
                          CHK_PREDICT, '0);
            for (k = 0; k < sig_len[s]; k++)
                send_item({msbm_pkg::KIND_SCAN, 4'($urandom), 5'($urandom), sig_mem[s][k],
                           (k == sig_len[s] - 1) && $urandom_range(0, 4) == 0},
                          CHK_PREDICT, '0);
        end
    endtask

    task automatic send_noise();
        int s;
        int p;
        logic [7:0] v;
        s = $urandom_range(0, msbm_pkg::NUM_SIGS - 1);
        case ($urandom_range(0, 4))
            0: send_item({KIND_UNUSED, 4'($urandom), 5'($urandom), 8'($urandom), 1'($urandom)},
                         CHK_PREDICT, '0);
            1: send_item({msbm_pkg::KIND_LOAD_BYTE, 4'(s), 5'($urandom), 8'($urandom),
                          1'($urandom)}, CHK_PREDICT, '0);
            2: begin
                // Never give a slot a length that reaches bytes not yet loaded.
                p = loaded_prefix(s);
                v = 8'($urandom_range(0, p));
                if (p == msbm_pkg::MAX_SIG_LEN && $urandom_range(0, 3) == 0)
                    v = 8'($urandom_range(33, 255));
                send_item({msbm_pkg::KIND_SET_LEN, 4'(s), 5'($urandom), v, 1'($urandom)},
                          CHK_PREDICT, '0);
            end
            default: send_item({msbm_pkg::KIND_SCAN, 4'($urandom), 5'($urandom), 8'($urandom),
                                $urandom_range(0, 4) == 0}, CHK_PREDICT, '0);
        endcase
    endtask

    // Receiver: random stalls, mostly short, some long, with quiet stretches.
    initial begin : stall_driver
        int stall_left;
        int r;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            r = $urandom_range(0, 99);
            if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else if ((cycle_count % 600) < 120) begin
                out_stall <= 1'b0;
            end else if (r < 25) begin
                stall_left = $urandom_range(0, 2);
                out_stall <= 1'b1;
            end else if (r < 28) begin
                stall_left = $urandom_range(10, 40);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (rst_n && out_valid && !out_stall) begin
            got_match = out_data;
            if (pending_matches.size() == 0) begin
                report_mismatch($sformatf("unexpected match: slot %0d offset %0d length %0d",
                                          got_match.match_slot, got_match.start_offset,
                                          got_match.match_length));
            end else begin
                want_match = pending_matches.pop_front();
                matches_checked++;
                if (got_match.start_offset != want_match.start_offset)
                    report_mismatch($sformatf("start_offset %0d, wanted %0d",
                                              got_match.start_offset, want_match.start_offset));
                if (got_match.match_slot != want_match.match_slot)
                    report_mismatch($sformatf("match_slot %0d, wanted %0d",
                                              got_match.match_slot, want_match.match_slot));
                if (got_match.match_length != want_match.match_length)
                    report_mismatch($sformatf("match_length %0d, wanted %0d",
                                              got_match.match_length, want_match.match_length));
                if (got_match.last_match != want_match.last_match)
                    report_mismatch($sformatf("last_match %0b, wanted %0b",
                                              got_match.last_match, want_match.last_match));
                if (got_match.offset_saturated != want_match.offset_saturated)
                    report_mismatch($sformatf("offset_saturated %0b, wanted %0b",
                                              got_match.offset_saturated,
                                              want_match.offset_saturated));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d matches outstanding.",
                     cycle_count, pending_matches.size());
            $display("[multi_signature_byte_matcher] ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        int r;
        bit drained;
        foreach (sig_len[s]) begin
            sig_len[s] = '0;
            loaded_mask[s] = '0;
            foreach (sig_mem[s][k])
                sig_mem[s][k] = '0;
        end
        foreach (hist[k])
            hist[k] = '0;
        scan_pos = '0;
        pos_sat = 1'b0;
        drained = 1'b0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        // Directed table; where a group's comment names a position, it is the position before that group.
        // Position 0: nothing loaded, so a scan finds nothing.
        add_row({msbm_pkg::KIND_SCAN,      4'd0,  5'd0,  8'h00, 1'b0}, CHK_NONE, '0);
        add_row({msbm_pkg::KIND_LOAD_BYTE, 4'd0,  5'd0,  8'hAB, 1'b0}, CHK_NONE, '0);
        add_row({msbm_pkg::KIND_LOAD_BYTE, 4'd0,  5'd1,  8'hCD, 1'b0}, CHK_NONE, '0);
        add_row({msbm_pkg::KIND_SET_LEN,   4'd0,  5'd0,  8'd2,  1'b0}, CHK_NONE, '0);
        add_row({msbm_pkg::KIND_SCAN,      4'd0,  5'd0,  8'hAB, 1'b0}, CHK_NONE, '0);
        add_row({msbm_pkg::KIND_SCAN,      4'd0,  5'd0,  8'hCD, 1'b0}, CHK_ONE,
                {24'd1, 4'd0, 6'd2, 1'b1, 1'b0});
        // Position 3: one-byte signature in the top slot, at the end of the buffer.
        add_row({msbm_pkg::KIND_LOAD_BYTE, 4'd15, 5'd0,  8'hFF, 1'b0}, CHK_NONE, '0);
        add_row({msbm_pkg::KIND_SET_LEN,   4'd15, 5'd0,  8'd1,  1'b0}, CHK_NONE, '0);
        add_row({msbm_pkg::KIND_SCAN,      4'd0,  5'd0,  8'hFF, 1'b1}, CHK_ONE,
                {24'd3, 4'd15, 6'd1, 1'b1, 1'b0});
        // The pair straddles a buffer boundary and must not match.
        add_row({msbm_pkg::KIND_SCAN,      4'd0,  5'd0,  8'hAB, 1'b1}, CHK_NONE, '0);
        add_row({msbm_pkg::KIND_SCAN,      4'd0,  5'd0,  8'hCD, 1'b0}, CHK_NONE, '0);
        // The unused kind does nothing, whatever its fields hold.
        add_row({KIND_UNUSED,              4'd15, 5'd31, 8'hFF, 1'b1}, CHK_NONE, '0);
        add_row({msbm_pkg::KIND_LOAD_BYTE, 4'd1,  5'd0,  8'hCD, 1'b0}, CHK_NONE, '0);
        add_row({msbm_pkg::KIND_SET_LEN,   4'd1,  5'd0,  8'd1,  1'b0}, CHK_NONE, '0);
        // Position 1: two slots end on the same byte.
        add_row({msbm_pkg::KIND_SCAN,      4'd0,  5'd0,  8'hAB, 1'b0}, CHK_NONE, '0);
        add_row({msbm_pkg::KIND_SCAN,      4'd0,  5'd0,  8'hCD, 1'b0}, CHK_PREDICT, '0);
        add_row({msbm_pkg::KIND_SCAN,      4'd0,  5'd0,  8'hAB, 1'b0}, CHK_NONE, '0);
        // Slot 0 emptied: AB CD is in the window again but only slot 1 answers.
        add_row({msbm_pkg::KIND_SET_LEN,   4'd0,  5'd0,  8'd0,  1'b0}, CHK_NONE, '0);
        add_row({msbm_pkg::KIND_SCAN,      4'd0,  5'd0,  8'hCD, 1'b0}, CHK_ONE,
                {24'd4, 4'd1, 6'd1, 1'b1, 1'b0});
        add_row({msbm_pkg::KIND_LOAD_BYTE, 4'd15, 5'd31, 8'h00, 1'b0}, CHK_NONE, '0);
        add_row({msbm_pkg::KIND_SCAN,      4'd0,  5'd0,  8'hFF, 1'b1}, CHK_ONE,
                {24'd5, 4'd15, 6'd1, 1'b1, 1'b0});
        add_row({msbm_pkg::KIND_SCAN,      4'd15, 5'd31, 8'h00, 1'b0}, CHK_NONE, '0);

        foreach (dir_items[i])
            send_item(dir_items[i], dir_checks[i], dir_wants[i]);

        while (items_sent < ITEM_TARGET) begin
            // Once, hold the input back until every outstanding match is out.
            if (!drained && items_sent >= ITEM_TARGET / 2) begin
                drained = 1'b1;
                @(negedge i_clk);
                in_valid <= 1'b0;
                while (pending_matches.size() != 0)
                    @(posedge i_clk);
            end
            r = $urandom_range(0, 99);
            if (r < 22)
                program_signature();
            else if (r < 55)
                scan_burst();
            else if (r < 78)
                scan_planted();
            else
                send_noise();
        end

        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending_matches.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d transactions, %0d of them scan bytes, over %0d cycles.",
                 items_sent, scans_sent, cycle_count);
        $display("Checked %0d matches against the predictor, %0d mismatches.",
                 matches_checked, mismatches);
        if (mismatches == 0)
            $display("[multi_signature_byte_matcher] OK");
        else
            $display("[multi_signature_byte_matcher] ERROR");
        $finish;
    end

endmodule
